// ===== src/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared types and constants for the front end and compression core.
// ----------------------------------------------------------------------------
package sha1_pkg;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   localparam logic CMD_ABSORB   = 1'b0;
   localparam logic CMD_FINALIZE = 1'b1;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   // work unit handed from front to back: one byte or a finalize
   typedef struct packed {
      logic       fin;
      logic [7:0] data;
   } qitem_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

endpackage

// ===== src/sha1_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts request transfers and queues them for the back end.
// ----------------------------------------------------------------------------
module sha1_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_cmd,
   input  logic [7:0]          req_data_byte,
   output sha1_pkg::qitem_type q_item,
   output logic                q_valid,
   input  logic                q_take
);
   import sha1_pkg::*;

   qitem_type          mem_ff [QDEPTH];
   logic [QAW-1:0]     wp_ff, rp_ff;
   logic [QAW:0]       cnt_ff;
   logic               push_ok, pop_ok;

   assign req_full = (cnt_ff == (QAW+1)'(QDEPTH));
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (cnt_ff != '0);
   assign pop_ok   = q_take && q_valid;
   assign q_item   = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wp_ff].fin  <= (req_cmd == CMD_FINALIZE);
         mem_ff[wp_ff].data <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_ok) wp_ff <= wp_ff + 1'b1;
         if (pop_ok)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QAW+1)'(push_ok) - (QAW+1)'(pop_ok);
      end
   end

endmodule

// ===== src/sha1_back.sv =====
// ----------------------------------------------------------------------------
// SHA-1 back end
// Buffers bytes, pads, runs 80 rounds one per cycle, emits digest words.
// ----------------------------------------------------------------------------
module sha1_back (
   input  logic                clock,
   input  logic                reset,
   input  sha1_pkg::qitem_type q_item,
   input  logic                q_valid,
   output logic                q_take,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_is_last
);
   import sha1_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PAD   = 5'b00010,
      S_ROUND = 5'b00100,
      S_EMIT  = 5'b01000,
      S_ADD   = 5'b10000
   } state_type;

   state_type    st_ff, st_in;
   logic [31:0]  w_ff [16];         // message / schedule window
   logic [31:0]  h_ff [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [63:0]  cnt_ff;
   logic [6:0]   rnd_ff;
   logic [5:0]   pos_ff;
   logic         fin_ff;            // digest pending after this block
   logic         lenblk_ff;         // current padded block carries length
   logic [2:0]   oi_ff;
   logic         ov_ff;

   logic [31:0]  wn, f, k, t, wcur;
   logic [7:0]   pbyte;
   logic [63:0]  bits;

   assign bits = cnt_ff << 3;
   assign wn   = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
   assign wcur = (rnd_ff < 7'd16) ? w_ff[0] : wn;

   always_comb begin
      priority if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = 32'h5A827999;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;             k = 32'h6ED9EBA1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;             k = 32'hCA62C1D6;
      end
   end
   assign t = rotl(a_ff, 5) + f + e_ff + k + wcur;

   // pad byte at pos_ff: zero, or length byte when in the length slot
   always_comb begin
      pbyte = 8'h00;
      if (lenblk_ff && pos_ff >= 6'd56)
         pbyte = bits[8*(7 - 32'(pos_ff[2:0])) +: 8];
   end

   assign q_take          = (st_ff == S_IDLE) && q_valid;
   assign rsp_empty       = !ov_ff;
   assign rsp_digest_word = h_ff[0];
   assign rsp_word_index  = oi_ff;
   assign rsp_is_last     = (oi_ff == 3'd4);

   // shift a byte into the window (big-endian, word 15 fills last)
   logic [7:0] sbyte;
   logic       shift_en;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE:  if (q_valid) begin
            // a byte or the 0x80 mark in the last slot closes the block
            if (pos_ff == 6'd63) st_in = S_ROUND;
            else if (q_item.fin) st_in = S_PAD;
         end
         S_PAD:   if (pos_ff == 6'd63) st_in = S_ROUND;
         S_ROUND: if (rnd_ff == 7'd79) st_in = S_ADD;
         S_ADD:   st_in = fin_ff ? (lenblk_ff ? S_EMIT : S_PAD) : S_IDLE;
         S_EMIT:  if (rsp_pop && ov_ff && oi_ff == 3'd4) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      shift_en = 1'b0;
      sbyte    = pbyte;
      if (st_ff == S_IDLE && q_valid) begin
         shift_en = 1'b1;
         sbyte    = q_item.fin ? 8'h80 : q_item.data;
      end else if (st_ff == S_PAD) begin
         shift_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < 15; i++)
            w_ff[i] <= {w_ff[i][23:0], w_ff[i+1][31:24]};
         w_ff[15] <= {w_ff[15][23:0], sbyte};
      end else if (st_ff == S_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wcur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         h_ff      <= '{IV0, IV1, IV2, IV3, IV4};
         cnt_ff    <= '0;
         rnd_ff    <= '0;
         pos_ff    <= '0;
         fin_ff    <= 1'b0;
         lenblk_ff <= 1'b0;
         oi_ff     <= '0;
         ov_ff     <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (shift_en) pos_ff <= pos_ff + 1'b1;
         unique case (st_ff)
            S_IDLE: if (q_valid) begin
               if (q_item.fin) begin
                  fin_ff    <= 1'b1;
                  lenblk_ff <= (pos_ff < 6'd56);
               end else begin
                  cnt_ff <= cnt_ff + 64'd1;
               end
               if (pos_ff == 6'd63) begin
                  {a_ff, b_ff, c_ff, d_ff, e_ff} <=
                     {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
                  rnd_ff <= '0;
               end
            end
            S_PAD: if (pos_ff == 6'd63) begin
               {a_ff, b_ff, c_ff, d_ff, e_ff} <=
                  {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
               rnd_ff <= '0;
            end
            S_ROUND: begin
               a_ff <= t; b_ff <= a_ff; c_ff <= rotl(b_ff, 30);
               d_ff <= c_ff; e_ff <= d_ff;
               rnd_ff <= rnd_ff + 1'b1;
            end
            S_ADD: begin
               h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               if (fin_ff && !lenblk_ff) lenblk_ff <= 1'b1;
               if (fin_ff && lenblk_ff) begin
                  ov_ff <= 1'b1;
                  oi_ff <= '0;
               end
            end
            S_EMIT: if (rsp_pop && ov_ff) begin
               oi_ff <= oi_ff + 1'b1;
               if (oi_ff == 3'd4) begin
                  ov_ff  <= 1'b0;
                  fin_ff <= 1'b0;
                  lenblk_ff <= 1'b0;
                  cnt_ff <= '0;
                  pos_ff <= '0;
                  h_ff   <= '{IV0, IV1, IV2, IV3, IV4};
               end else begin
                  // rotate words so word 0 of the port is always next
                  h_ff[0] <= h_ff[1]; h_ff[1] <= h_ff[2]; h_ff[2] <= h_ff[3];
                  h_ff[3] <= h_ff[4]; h_ff[4] <= h_ff[0];
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== src/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-serial SHA-1 engine with a queued front end and compression back end.
// ----------------------------------------------------------------------------
// Absorb: each byte enters the front-end queue; every 64th byte starts an
// 80-round compression, while the queue keeps taking bytes until it is full.
// Finalize: pad bytes one per cycle up to the block end, one compression per
// block, then five digest words, one per pop; the core does one round per cycle.
// Synchronous active-high reset restores the initial value and zero count.
module sha1_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_is_last
);
   import sha1_pkg::*;

   qitem_type q_item;
   logic      q_valid, q_take;

   // front: small queue decouples request transfers from compression stalls
   sha1_front u_front (
      .clock, .reset, .req_push, .req_full, .req_cmd, .req_data_byte,
      .q_item, .q_valid, .q_take
   );

   // back: block assembly, padding, 80-round core and digest output
   sha1_back u_back (
      .clock, .reset, .q_item, .q_valid, .q_take,
      .rsp_empty, .rsp_pop, .rsp_digest_word, .rsp_word_index, .rsp_is_last
   );

endmodule
